// ===== hw/rtl/fctm_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT16 cluster table manager package
// Command and status codes, table constants and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package fctm_pkg;

  // Cluster indexes are compared against the table bound in this width; it
  // covers a 16-bit cluster number and a table of up to 65536 entries.
  localparam int IDX_W = 17;

  localparam logic [15:0] FIRST_DATA_CLUSTER = 16'h0002;
  localparam logic [15:0] RESERVED_LIMIT     = 16'hFFF8;
  localparam logic [15:0] END_MARK           = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FAT_START   = 3'd0;
  localparam logic [2:0] CFG_TABLE_SECT  = 3'd1;
  localparam logic [2:0] CFG_FAT_COPIES  = 3'd2;
  localparam logic [2:0] CFG_SECT_PER_CL = 3'd3;
  localparam logic [2:0] CFG_ENTRIES     = 3'd4;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_NEXT   = 3'd1,
    CMD_ALLOC  = 3'd2,
    CMD_FREE   = 3'd3,
    CMD_SECTOR = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_LOOP    = 2'd3
  } status_t;

  // Disk geometry handed to the sector unit.
  typedef struct packed {
    logic [31:0] fat_base_sector;
    logic [15:0] fat_table_sectors;
    logic [2:0]  fat_copies;
    logic [7:0]  sectors_per_cluster;
  } sector_cfg_t;

  function automatic logic is_valid(input logic [15:0] c);
    return (c >= FIRST_DATA_CLUSTER) && (c < RESERVED_LIMIT);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fctm_table_ram.sv =====
// ----------------------------------------------------------------------------
// FAT table memory
// One write port and one read port, registered read data, write-first
// bypass when both ports hit the same entry in one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fctm_table_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] mem_q;
  logic [15:0] byp_data;
  logic        byp;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q    <= mem[raddr];
    byp      <= we && (waddr == raddr);
    byp_data <= wdata;
  end

  assign rdata = byp ? byp_data : mem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fctm_sector.sv =====
// ----------------------------------------------------------------------------
// First sector unit
// Computes the first data sector of a cluster in two register stages:
// products first, then the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module fctm_sector
  import fctm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire sector_cfg_t geo,
  input  wire logic [15:0] cluster,
  output logic             done,
  output logic      [31:0] sector
);

  logic [18:0] fat_area;
  logic [23:0] data_offs;
  logic [31:0] base;
  logic        prod_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      prod_vld <= start;
      done     <= prod_vld;
    end
    fat_area  <= 19'(geo.fat_table_sectors * geo.fat_copies);
    data_offs <= 24'((cluster - FIRST_DATA_CLUSTER) * geo.sectors_per_cluster);
    base      <= geo.fat_base_sector;
    sector    <= base + 32'(fat_area) + 32'(data_offs);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fat16_cluster_table_manager_core.sv =====
// Load entry and rejected commands go straight to the output register state;
// next cluster reads the table first, first sector waits on the sector unit,
// allocate scans for the first free entry, and free chain clears one entry per
// step until the chain ends or hits a limit. Throughput: one command at a time;
// the scan and the chain walk over the single table read port set the worst case.
// Reset clears control state and sets configuration to defaults; the table must be loaded.
// ----------------------------------------------------------------------------
// FAT16 cluster table manager
// Command sequencer around the FAT table memory: load, lookup, first-fit
// allocate, chain free and first sector computation.
// ----------------------------------------------------------------------------
`default_nettype none

module fat16_cluster_table_manager_core
  import fctm_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  cmd,
  input  wire logic [15:0] cluster,
  input  wire logic [15:0] entry_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] cluster_value,
  output logic      [31:0] sector_number,
  output logic      [12:0] freed_count,
  output logic      [1:0]  status
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] TE_LIM = IDX_W'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_NEXT, S_SCAN, S_LINK, S_MARK, S_FREE, S_SECT, S_RESP
  } state_t;

  state_t state;

  // Configuration.
  logic [31:0] fat_base_sector;
  logic [15:0] fat_table_sectors;
  logic [2:0]  fat_copies;
  logic [7:0]  sectors_per_cluster;
  logic [12:0] entries_in_use;

  // Command context.
  logic [15:0]      cur;
  logic [15:0]      link;
  logic             link_en;
  logic [15:0]      found;
  logic [IDX_W-1:0] iss;
  logic [IDX_W-1:0] chk;
  logic             pend;
  logic [12:0]      freed;

  // Staged result.
  logic [15:0] res_cval;
  logic [31:0] res_sector;
  logic [12:0] res_freed;
  status_t     res_status;

  logic [IDX_W-1:0] eiu_ext;
  logic [IDX_W-1:0] lim;
  logic             in_tab;
  logic             cl_ok;
  logic             accept;
  logic [12:0]      freed_inc;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  sector_cfg_t geo;
  logic        sect_start;
  logic        sect_done;
  logic [31:0] sect_value;

  assign eiu_ext   = IDX_W'(entries_in_use);
  assign lim       = (eiu_ext > TE_LIM) ? TE_LIM : eiu_ext;
  assign in_tab    = IDX_W'(cluster) < lim;
  assign cl_ok     = is_valid(cluster) && in_tab;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign freed_inc = freed + 13'd1;

  assign geo.fat_base_sector     = fat_base_sector;
  assign geo.fat_table_sectors   = fat_table_sectors;
  assign geo.fat_copies          = fat_copies;
  assign geo.sectors_per_cluster = sectors_per_cluster;
  assign sect_start = accept && (cmd_t'(cmd) == CMD_SECTOR) && cl_ok;

  // Memory port steering.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cluster[AW-1:0];
    ram_wdata = entry_value;
    ram_raddr = cluster[AW-1:0];
    case (state)
      S_IDLE: begin
        ram_we = accept && (cmd_t'(cmd) == CMD_LOAD) && in_tab;
      end
      S_SCAN: begin
        ram_raddr = iss[AW-1:0];
      end
      S_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = link[AW-1:0];
        ram_wdata = found;
      end
      S_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = found[AW-1:0];
        ram_wdata = END_MARK;
      end
      S_FREE: begin
        // Clear the current link while fetching the next one.
        ram_we    = 1'b1;
        ram_waddr = cur[AW-1:0];
        ram_wdata = 16'h0000;
        ram_raddr = ram_rdata[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  fctm_table_ram #(
    .DEPTH(TABLE_ENTRIES),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  fctm_sector u_sector (
    .clk    (clk),
    .rst    (rst),
    .start  (sect_start),
    .geo    (geo),
    .cluster(cluster),
    .done   (sect_done),
    .sector (sect_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fat_base_sector     <= 32'd0;
      fat_table_sectors   <= 16'd1;
      fat_copies          <= 3'd2;
      sectors_per_cluster <= 8'd1;
      entries_in_use      <= 13'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FAT_START:   fat_base_sector     <= cfg_data;
        CFG_TABLE_SECT:  fat_table_sectors   <= cfg_data[15:0];
        CFG_FAT_COPIES:  fat_copies          <= cfg_data[2:0];
        CFG_SECT_PER_CL: sectors_per_cluster <= cfg_data[7:0];
        CFG_ENTRIES:     entries_in_use      <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      // In S_RESP the valid flag is driven by the state below.
      if (out_valid && !out_stall && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_cval   <= 16'h0000;
            res_sector <= 32'd0;
            res_freed  <= 13'd0;
            res_status <= ST_OK;
            cur        <= cluster;
            freed      <= 13'd0;
            unique case (cmd_t'(cmd))
              CMD_LOAD: begin
                res_status <= in_tab ? ST_OK : ST_INVALID;
                state      <= S_RESP;
              end
              CMD_NEXT: begin
                if (cl_ok) begin
                  state <= S_NEXT;
                end else begin
                  res_cval   <= END_MARK;
                  res_status <= ST_INVALID;
                  state      <= S_RESP;
                end
              end
              CMD_ALLOC: begin
                if (is_valid(cluster) && !in_tab) begin
                  res_cval   <= END_MARK;
                  res_status <= ST_INVALID;
                  state      <= S_RESP;
                end else begin
                  link    <= cluster;
                  link_en <= is_valid(cluster);
                  iss     <= IDX_W'(FIRST_DATA_CLUSTER);
                  pend    <= 1'b0;
                  state   <= S_SCAN;
                end
              end
              CMD_FREE: begin
                if (!cl_ok) begin
                  res_status <= ST_INVALID;
                  state      <= S_RESP;
                end else if (entries_in_use == 13'd0) begin
                  res_status <= ST_LOOP;
                  state      <= S_RESP;
                end else begin
                  state <= S_FREE;
                end
              end
              CMD_SECTOR: begin
                if (cl_ok) begin
                  state <= S_SECT;
                end else begin
                  res_status <= ST_INVALID;
                  state      <= S_RESP;
                end
              end
              default: begin
                res_cval   <= END_MARK;
                res_status <= ST_INVALID;
                state      <= S_RESP;
              end
            endcase
          end
        end
        S_NEXT: begin
          res_cval <= ram_rdata;
          state    <= S_RESP;
        end
        S_SCAN: begin
          // Reads run one entry ahead of the zero test.
          if (pend && (ram_rdata == 16'h0000)) begin
            found <= chk[15:0];
            pend  <= 1'b0;
            state <= link_en ? S_LINK : S_MARK;
          end else if (iss < lim) begin
            pend <= 1'b1;
            chk  <= iss;
            iss  <= iss + IDX_W'(1);
          end else begin
            pend       <= 1'b0;
            res_cval   <= END_MARK;
            res_status <= ST_FULL;
            state      <= S_RESP;
          end
        end
        S_LINK: begin
          state <= S_MARK;
        end
        S_MARK: begin
          res_cval <= found;
          state    <= S_RESP;
        end
        S_FREE: begin
          freed     <= freed_inc;
          res_freed <= freed_inc;
          cur       <= ram_rdata;
          if (!is_valid(ram_rdata)) begin
            res_status <= ST_OK;
            state      <= S_RESP;
          end else if (IDX_W'(ram_rdata) >= lim) begin
            res_status <= ST_INVALID;
            state      <= S_RESP;
          end else if (freed_inc >= entries_in_use) begin
            res_status <= ST_LOOP;
            state      <= S_RESP;
          end
        end
        S_SECT: begin
          if (sect_done) begin
            res_sector <= sect_value;
            state      <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            cluster_value <= res_cval;
            sector_number <= res_sector;
            freed_count   <= res_freed;
            status        <= res_status;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fctm_checker.sv =====
// ----------------------------------------------------------------------------
// FAT16 cluster table manager checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fctm_checker
  import fctm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] cluster_value,
  input wire logic [31:0] sector_number,
  input wire logic [12:0] freed_count,
  input wire logic [1:0]  status
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cluster_value)
      && $stable(sector_number) && $stable(freed_count) && $stable(status))
    else $error("result beat changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Only a successful first sector command reports a sector.
  a_sector_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> sector_number == 32'd0)
    else $error("sector reported on a failed command");

  // A chain free reports no cluster and no sector.
  a_freed_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (freed_count != 13'd0) |-> (cluster_value == 16'h0000)
      && (sector_number == 32'd0))
    else $error("freed count mixed with other results");

  a_full_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> cluster_value == END_MARK)
    else $error("table full without end mark");

endmodule

bind fat16_cluster_table_manager_core fctm_checker u_fctm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .cluster_value(cluster_value),
  .sector_number(sector_number),
  .freed_count  (freed_count),
  .status       (status)
);

`default_nettype wire
